>>> rtl/core/plist_pkg.sv
// Package for the positional list engine: operation and status codes,
// default sizes, controller state type and the controller/datapath structs.
// Used by every module under rtl/core.
package plist_pkg;

   localparam int CAPACITY_DEF    = 16;
   localparam int VALUE_WIDTH_DEF = 32;

   localparam logic [1:0] MODE_INSERT = 2'd0;
   localparam logic [1:0] MODE_DELETE = 2'd1;
   localparam logic [1:0] MODE_SEARCH = 2'd2;

   localparam logic [1:0] ST_DONE     = 2'd0;
   localparam logic [1:0] ST_FULL     = 2'd1;
   localparam logic [1:0] ST_RANGE    = 2'd2;
   localparam logic [1:0] ST_NOTFOUND = 2'd3;

   typedef enum logic [2:0] {
      S_IDLE,
      S_READ,
      S_DRAIN,
      S_PLACE,
      S_REPLY
   } state_type;

   typedef struct packed {
      logic load;
      logic issue;
      logic place;
      logic publish;
   } dp_cmd_type;

   typedef struct packed {
      logic chk_work;
      logic chk_place_only;
      logic op_insert;
      logic last_rd;
   } dp_status_type;

endpackage

>>> rtl/core/plist_dpath.sv
// Datapath of the positional list engine: list memory, shift and scan
// pointers, request and result registers. Driven by plist_ctrl; uses plist_pkg.
module plist_dpath
   import plist_pkg::*;
#(
   parameter int CAPACITY    = CAPACITY_DEF,
   parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
   input  logic                clock,
   input  logic                reset,
   input  logic [1:0]          req_mode,
   input  logic [4:0]          req_position,
   input  logic signed [31:0]  req_value_in,
   input  dp_cmd_type          cmd,
   output dp_status_type       stat,
   output logic [1:0]          rsp_status,
   output logic signed [31:0]  rsp_value_out,
   output logic [4:0]          rsp_found_position,
   output logic [4:0]          rsp_element_count,
   output logic                rsp_is_empty
);

   localparam int CW = $clog2(CAPACITY + 1);
   localparam int IW = $clog2(CAPACITY);
   localparam int EW = ((CW > 5) ? CW : 5) + 1;

   logic [VALUE_WIDTH-1:0] mem [CAPACITY];

   logic [CW-1:0]          count_ff, count_in;
   logic [1:0]             mode_ff;
   logic [IW-1:0]          pos_idx_ff;
   logic [VALUE_WIDTH-1:0] val_ff;
   logic [IW-1:0]          ptr_ff, ptr_in;
   logic [IW-1:0]          end_ff, end_in;
   logic [IW-1:0]          raddr_ff;
   logic                   rvalid_ff;
   logic                   first_ff, first_in;
   logic [VALUE_WIDTH-1:0] rdata_ff;
   logic [1:0]             work_status_ff, work_status_in;
   logic [VALUE_WIDTH-1:0] removed_ff, removed_in;
   logic [CW-1:0]          found_ff, found_in;

   logic [1:0]             out_status_ff;
   logic [VALUE_WIDTH-1:0] out_value_ff;
   logic [CW-1:0]          out_found_ff;
   logic [CW-1:0]          out_count_ff;

   logic [EW-1:0]          pos_e, cnt_e;
   logic                   ins_full, ins_range, del_range;
   logic [1:0]             chk_status;
   logic [IW-1:0]          req_pos_idx, cnt_idx_m1;
   logic                   move_we;
   logic [IW-1:0]          move_addr;
   logic                   match;

   always_comb begin
      pos_e       = EW'(req_position);
      cnt_e       = EW'(count_ff);
      ins_full    = cnt_e >= EW'(CAPACITY);
      ins_range   = (pos_e == '0) || (pos_e > cnt_e + EW'(1));
      del_range   = (cnt_e == '0) || (pos_e == '0) || (pos_e > cnt_e);
      req_pos_idx = IW'(req_position - 5'd1);
      cnt_idx_m1  = IW'(count_ff - CW'(1));
      case (req_mode)
         MODE_INSERT: begin
            chk_status = ins_full ? ST_FULL : (ins_range ? ST_RANGE : ST_DONE);
         end
         MODE_DELETE: begin
            chk_status = del_range ? ST_RANGE : ST_DONE;
         end
         MODE_SEARCH: begin
            chk_status = ST_NOTFOUND;
         end
         default: begin
            chk_status = ST_RANGE;
         end
      endcase
      stat.chk_work = ((req_mode == MODE_INSERT) && !ins_full && !ins_range)
                   || ((req_mode == MODE_DELETE) && !del_range)
                   || ((req_mode == MODE_SEARCH) && (count_ff != '0));
      stat.chk_place_only = (req_mode == MODE_INSERT) && (pos_e == cnt_e + EW'(1));
      stat.op_insert      = (mode_ff == MODE_INSERT);
      stat.last_rd        = (ptr_ff == end_ff);
   end

   always_comb begin
      move_we   = rvalid_ff && ((mode_ff == MODE_INSERT) ||
                                ((mode_ff == MODE_DELETE) && !first_ff));
      move_addr = (mode_ff == MODE_INSERT) ? raddr_ff + IW'(1) : raddr_ff - IW'(1);
      match     = rvalid_ff && (mode_ff == MODE_SEARCH) && (rdata_ff == val_ff);

      ptr_in         = ptr_ff;
      end_in         = end_ff;
      first_in       = first_ff;
      work_status_in = work_status_ff;
      removed_in     = removed_ff;
      found_in       = found_ff;
      count_in       = count_ff;

      if (cmd.load) begin
         first_in       = 1'b1;
         work_status_in = chk_status;
         removed_in     = '0;
         found_in       = '0;
         case (req_mode)
            MODE_INSERT: begin
               ptr_in = cnt_idx_m1;
               end_in = req_pos_idx;
            end
            MODE_DELETE: begin
               ptr_in = req_pos_idx;
               end_in = cnt_idx_m1;
            end
            default: begin
               ptr_in = '0;
               end_in = cnt_idx_m1;
            end
         endcase
      end else begin
         if (cmd.issue) begin
            ptr_in = (mode_ff == MODE_INSERT) ? ptr_ff - IW'(1) : ptr_ff + IW'(1);
         end
         if (rvalid_ff) begin
            first_in = 1'b0;
            if ((mode_ff == MODE_DELETE) && first_ff) begin
               removed_in = rdata_ff;
            end
         end
         if (match && (work_status_ff == ST_NOTFOUND)) begin
            work_status_in = ST_DONE;
            found_in       = CW'(raddr_ff) + CW'(1);
         end
      end

      if (cmd.publish && (work_status_ff == ST_DONE)) begin
         if (mode_ff == MODE_INSERT) begin
            count_in = count_ff + CW'(1);
         end else if (mode_ff == MODE_DELETE) begin
            count_in = count_ff - CW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff  <= '0;
         rvalid_ff <= 1'b0;
      end else begin
         count_ff  <= count_in;
         rvalid_ff <= cmd.issue;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         mode_ff    <= req_mode;
         pos_idx_ff <= req_pos_idx;
         val_ff     <= VALUE_WIDTH'($unsigned(req_value_in));
      end
      if (cmd.issue) begin
         raddr_ff <= ptr_ff;
      end
      ptr_ff         <= ptr_in;
      end_ff         <= end_in;
      first_ff       <= first_in;
      work_status_ff <= work_status_in;
      removed_ff     <= removed_in;
      found_ff       <= found_in;
      if (cmd.publish) begin
         out_status_ff <= work_status_ff;
         out_value_ff  <= removed_ff;
         out_found_ff  <= found_ff;
         out_count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.issue) begin
         rdata_ff <= mem[ptr_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.place) begin
         mem[pos_idx_ff] <= val_ff;
      end else if (move_we) begin
         mem[move_addr] <= rdata_ff;
      end
   end

   assign rsp_status         = out_status_ff;
   assign rsp_value_out      = 32'(out_value_ff);
   assign rsp_found_position = 5'(out_found_ff);
   assign rsp_element_count  = 5'(out_count_ff);
   assign rsp_is_empty       = (out_count_ff == '0);

endmodule

>>> rtl/core/plist_ctrl.sv
// Controller of the positional list engine: sequences read, drain, place
// and reply steps and owns both handshakes. Uses plist_pkg.
module plist_ctrl
   import plist_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_stall,
   output logic          rsp_valid,
   input  logic          rsp_stall,
   input  dp_status_type stat,
   output dp_cmd_type    cmd
);

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      out_free;

   assign out_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               if (!stat.chk_work) begin
                  state_in = S_REPLY;
               end else if (stat.chk_place_only) begin
                  state_in = S_PLACE;
               end else begin
                  state_in = S_READ;
               end
            end
         end
         S_READ: begin
            if (stat.last_rd) begin
               state_in = S_DRAIN;
            end
         end
         S_DRAIN: begin
            state_in = stat.op_insert ? S_PLACE : S_REPLY;
         end
         S_PLACE: begin
            state_in = S_REPLY;
         end
         S_REPLY: begin
            if (out_free) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      cmd          = '0;
      req_stall    = 1'b1;
      case (state_ff)
         S_IDLE: begin
            req_stall = 1'b0;
            cmd.load  = req_valid;
         end
         S_READ: begin
            cmd.issue = 1'b1;
         end
         S_PLACE: begin
            cmd.place = 1'b1;
         end
         S_REPLY: begin
            cmd.publish = out_free;
         end
         default: begin
            cmd = '0;
         end
      endcase
      rsp_valid_in = cmd.publish || (rsp_valid_ff && rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

>>> rtl/core/positional_list_engine.sv
// Positional list engine top level: controller plus datapath over plist_pkg.
// Steps: a rejected request or an empty search goes straight to reply, an append to place
// then reply, a delete or search reads entries (one a cycle) then drains and replies, and
// other inserts read, drain, place and reply. The engine stalls requests until the result
// is published, and longer while a finished result waits on a stalled output register.
// Synchronous reset empties the list at once; list memory contents are not cleared.
module positional_list_engine
   import plist_pkg::*;
#(
   parameter int CAPACITY    = CAPACITY_DEF,
   parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [1:0]         req_mode,
   input  logic [4:0]         req_position,
   input  logic signed [31:0] req_value_in,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [1:0]         rsp_status,
   output logic signed [31:0] rsp_value_out,
   output logic [4:0]         rsp_found_position,
   output logic [4:0]         rsp_element_count,
   output logic               rsp_is_empty
);

   dp_cmd_type    cmd;
   dp_status_type stat;

   plist_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .stat      (stat),
      .cmd       (cmd)
   );

   plist_dpath #(
      .CAPACITY    (CAPACITY),
      .VALUE_WIDTH (VALUE_WIDTH)
   ) u_dpath (
      .clock              (clock),
      .reset              (reset),
      .req_mode           (req_mode),
      .req_position       (req_position),
      .req_value_in       (req_value_in),
      .cmd                (cmd),
      .stat               (stat),
      .rsp_status         (rsp_status),
      .rsp_value_out      (rsp_value_out),
      .rsp_found_position (rsp_found_position),
      .rsp_element_count  (rsp_element_count),
      .rsp_is_empty       (rsp_is_empty)
   );

   a_accept_blocks: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("request accepted while another was in work");

   a_idle_no_work: assert property (@(posedge clock) disable iff (reset)
      !req_stall |-> !(cmd.issue || cmd.place || cmd.publish))
      else $error("datapath command issued while accepting requests");

   a_publish_valid: assert property (@(posedge clock) disable iff (reset)
      cmd.publish |=> rsp_valid)
      else $error("published result not presented");

   a_fail_clean: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_status != ST_DONE)) |->
         ((rsp_value_out == 32'sd0) && (rsp_found_position == 5'd0)))
      else $error("failed request reported a value or position");

endmodule
